// File: design/rapd_pkg.sv
// Shared types, constants and codes for the radar afterglow pixel decay block.
`timescale 1ns / 1ps

package rapd_pkg;

  // Default geometry and colour width
  localparam int unsigned MainSideDefault   = 512;
  localparam int unsigned WindowSideDefault = 256;
  localparam int unsigned ColorBits         = 16;
  localparam int unsigned PaletteDepth      = 256;

  // Field widths
  localparam int unsigned LevelBits = 8;
  localparam int unsigned LayerBits = 2;
  localparam int unsigned CoordBits = 10;
  localparam int unsigned OutCoordBits = 9;
  localparam int unsigned CfgIndexBits = 3;
  localparam int unsigned CfgDataBits  = 10;

  // Layers below this are visible
  localparam logic [LayerBits-1:0] VisibleLayers = 2'd2;

  // Register reset values
  localparam logic [7:0] DecayWeightReset  = 8'd60;
  localparam logic [9:0] MainWidthReset    = 10'd512;
  localparam logic [9:0] MainHeightReset   = 10'd512;
  localparam logic [8:0] WindowWidthReset  = 9'd256;
  localparam logic [8:0] WindowHeightReset = 9'd256;

  typedef enum logic [2:0] {
    ModeDecay      = 3'd0,
    ModeLoadMain   = 3'd1,
    ModeLoadWindow = 3'd2,
    ModeMainPal    = 3'd3,
    ModeWindowPal  = 3'd4
  } rapd_mode_e;

  typedef enum logic [CfgIndexBits-1:0] {
    CfgDecayWeight  = 3'd0,
    CfgMainWidth    = 3'd1,
    CfgMainHeight   = 3'd2,
    CfgWindowWidth  = 3'd3,
    CfgWindowHeight = 3'd4,
    CfgWindowEnable = 3'd5,
    CfgDecayEnable  = 3'd6
  } rapd_cfg_idx_e;

  typedef enum logic [1:0] {
    StIdle,
    StModify,
    StOutMain,
    StOutWindow
  } rapd_state_e;

  typedef struct packed {
    logic [7:0] decay_weight;
    logic [9:0] main_width;
    logic [9:0] main_height;
    logic [8:0] window_width;
    logic [8:0] window_height;
    logic       window_enable;
    logic       decay_enable;
  } rapd_cfg_t;

  // Main display pixel word
  typedef struct packed {
    logic [LevelBits-1:0] level;
    logic [LayerBits-1:0] layer;
    logic                 overlay_flag;
  } rapd_main_pix_t;

  // Window pixel word
  typedef struct packed {
    logic [LevelBits-1:0] level;
    logic [LayerBits-1:0] layer;
  } rapd_win_pix_t;

  // Palette write request
  typedef struct packed {
    logic                    main_we;
    logic                    win_we;
    logic [7:0]              idx;
    logic [ColorBits-1:0]    color;
  } rapd_pal_wr_t;

endpackage

// File: design/rapd_cfg_regs.sv
// Configuration register file for the afterglow decay block.
`timescale 1ns / 1ps

module rapd_cfg_regs (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  we_i,
  input  logic [rapd_pkg::CfgIndexBits-1:0]     index_i,
  input  logic [rapd_pkg::CfgDataBits-1:0]      data_i,
  output rapd_pkg::rapd_cfg_t                   cfg_o
);

  rapd_pkg::rapd_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (rapd_pkg::rapd_cfg_idx_e'(index_i))
        rapd_pkg::CfgDecayWeight:  cfg_d.decay_weight  = data_i[7:0];
        rapd_pkg::CfgMainWidth:    cfg_d.main_width    = data_i[9:0];
        rapd_pkg::CfgMainHeight:   cfg_d.main_height   = data_i[9:0];
        rapd_pkg::CfgWindowWidth:  cfg_d.window_width  = data_i[8:0];
        rapd_pkg::CfgWindowHeight: cfg_d.window_height = data_i[8:0];
        rapd_pkg::CfgWindowEnable: cfg_d.window_enable = data_i[0];
        rapd_pkg::CfgDecayEnable:  cfg_d.decay_enable  = data_i[0];
        default: ;  // unused index, dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.decay_weight  <= rapd_pkg::DecayWeightReset;
      cfg_q.main_width    <= rapd_pkg::MainWidthReset;
      cfg_q.main_height   <= rapd_pkg::MainHeightReset;
      cfg_q.window_width  <= rapd_pkg::WindowWidthReset;
      cfg_q.window_height <= rapd_pkg::WindowHeightReset;
      cfg_q.window_enable <= 1'b0;
      cfg_q.decay_enable  <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: design/rapd_pixel_store.sv
// Pixel stores: main and window intensity/layer memories, overlay colours, clear sweep.
`timescale 1ns / 1ps

module rapd_pixel_store #(
  parameter int unsigned MAIN_SIDE   = rapd_pkg::MainSideDefault,
  parameter int unsigned WINDOW_SIDE = rapd_pkg::WindowSideDefault,
  localparam int unsigned MainCells  = MAIN_SIDE * MAIN_SIDE,
  localparam int unsigned WinCells   = WINDOW_SIDE * WINDOW_SIDE,
  localparam int unsigned MainAw     = $clog2(MainCells),
  localparam int unsigned WinAw      = $clog2(WinCells)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  output logic                                clearing_o,
  // read port, shared enable
  input  logic                                rd_en_i,
  input  logic [MainAw-1:0]                   main_raddr_i,
  input  logic [WinAw-1:0]                    win_raddr_i,
  output rapd_pkg::rapd_main_pix_t            main_rdata_o,
  output logic [rapd_pkg::ColorBits-1:0]      ovl_rdata_o,
  output rapd_pkg::rapd_win_pix_t             win_rdata_o,
  // write ports
  input  logic                                main_we_i,
  input  logic [MainAw-1:0]                   main_waddr_i,
  input  rapd_pkg::rapd_main_pix_t            main_wdata_i,
  input  logic                                ovl_we_i,
  input  logic [rapd_pkg::ColorBits-1:0]      ovl_wdata_i,
  input  logic                                win_we_i,
  input  logic [WinAw-1:0]                    win_waddr_i,
  input  rapd_pkg::rapd_win_pix_t             win_wdata_i
);

  localparam int unsigned ClrCells = (MainCells > WinCells) ? MainCells : WinCells;
  localparam int unsigned ClrAw    = $clog2(ClrCells);

  rapd_pkg::rapd_main_pix_t         main_mem [MainCells];
  rapd_pkg::rapd_win_pix_t          win_mem  [WinCells];
  logic [rapd_pkg::ColorBits-1:0]   ovl_mem  [MainCells];

  logic             clearing_q, clearing_d;
  logic [ClrAw-1:0] clr_cnt_q, clr_cnt_d;

  logic                     m_we, w_we;
  logic [MainAw-1:0]        m_wa;
  logic [WinAw-1:0]         w_wa;
  rapd_pkg::rapd_main_pix_t m_wd;
  rapd_pkg::rapd_win_pix_t  w_wd;

  // Sweep after reset writes zeros through both stores
  always_comb begin
    clearing_d = clearing_q;
    clr_cnt_d  = clr_cnt_q;
    if (clearing_q) begin
      clr_cnt_d = clr_cnt_q + 1'b1;
      if (clr_cnt_q == ClrAw'(ClrCells - 1)) clearing_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else begin
      clearing_q <= clearing_d;
      clr_cnt_q  <= clr_cnt_d;
    end
  end

  always_comb begin
    if (clearing_q) begin
      m_we = ({1'b0, clr_cnt_q} < (ClrAw + 1)'(MainCells));
      w_we = ({1'b0, clr_cnt_q} < (ClrAw + 1)'(WinCells));
      m_wa = clr_cnt_q[MainAw-1:0];
      w_wa = clr_cnt_q[WinAw-1:0];
      m_wd = '0;
      w_wd = '0;
    end else begin
      m_we = main_we_i;
      w_we = win_we_i;
      m_wa = main_waddr_i;
      w_wa = win_waddr_i;
      m_wd = main_wdata_i;
      w_wd = win_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (m_we) main_mem[m_wa] <= m_wd;
    if (rd_en_i) main_rdata_o <= main_mem[main_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (w_we) win_mem[w_wa] <= w_wd;
    if (rd_en_i) win_rdata_o <= win_mem[win_raddr_i];
  end

  // Overlay colours: no clear, only meaningful once loaded
  always_ff @(posedge clk_i) begin
    if (ovl_we_i && !clearing_q) ovl_mem[main_waddr_i] <= ovl_wdata_i;
    if (rd_en_i) ovl_rdata_o <= ovl_mem[main_raddr_i];
  end

  assign clearing_o = clearing_q;

endmodule

// File: design/rapd_palette.sv
// Main and window colour palettes, 256 entries each, registered read.
`timescale 1ns / 1ps

module rapd_palette (
  input  logic                                 clk_i,
  input  rapd_pkg::rapd_pal_wr_t               wr_i,
  input  logic                                 rd_en_i,
  input  logic [rapd_pkg::LevelBits-1:0]       main_ridx_i,
  input  logic [rapd_pkg::LevelBits-1:0]       win_ridx_i,
  output logic [rapd_pkg::ColorBits-1:0]       main_color_o,
  output logic [rapd_pkg::ColorBits-1:0]       win_color_o
);

  logic [rapd_pkg::ColorBits-1:0] main_pal [rapd_pkg::PaletteDepth];
  logic [rapd_pkg::ColorBits-1:0] win_pal  [rapd_pkg::PaletteDepth];

  always_ff @(posedge clk_i) begin
    if (wr_i.main_we) main_pal[wr_i.idx] <= wr_i.color;
    if (rd_en_i) main_color_o <= main_pal[main_ridx_i];
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.win_we) win_pal[wr_i.idx] <= wr_i.color;
    if (rd_en_i) win_color_o <= win_pal[win_ridx_i];
  end

endmodule

// File: design/radar_afterglow_pixel_decay_top.sv
// Top level of the radar afterglow pixel decay block.
`timescale 1ns / 1ps

// Radar afterglow fade engine. Items are taken on start while busy is low.
// Loads (pixel or palette) leave busy low, so loads can be issued every
// cycle while no decay or reset sweep holds busy high. A decay item reads the
// pixel stores at accept, writes back the faded levels and looks up the
// palettes in the modify state, then gives its framebuffer writes, at most
// two (main, then window); both are synchronous memories with registered read.
// A decay item with decay disabled, and modes 5 to 7, also leave busy low.
// Results appear for exactly one cycle with result_valid_o high and cannot be
// held off; last_write_o marks the final result of an item. After reset the
// pixel stores are swept to zero, one entry per cycle, over
// max(MAIN_SIDE, WINDOW_SIDE)^2 entries (262144 at the defaults); busy stays
// high meanwhile, though configuration transfers are taken throughout.
// The user must write configuration only while busy is low (not enforced).

module radar_afterglow_pixel_decay_top #(
  parameter int unsigned MAIN_SIDE   = rapd_pkg::MainSideDefault,
  parameter int unsigned WINDOW_SIDE = rapd_pkg::WindowSideDefault
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // command channel
  input  logic                                  start,
  output logic                                  busy,
  input  logic [2:0]                            mode_i,
  input  logic [rapd_pkg::CoordBits-1:0]        xpos_i,
  input  logic [rapd_pkg::CoordBits-1:0]        ypos_i,
  input  logic [rapd_pkg::LevelBits-1:0]        level_i,
  input  logic [rapd_pkg::LayerBits-1:0]        layer_num_i,
  input  logic                                  overlay_on_i,
  input  logic [rapd_pkg::ColorBits-1:0]        overlay_color_i,
  input  logic [7:0]                            palette_index_i,
  input  logic [rapd_pkg::ColorBits-1:0]        palette_color_i,
  // result strobe
  output logic                                  result_valid_o,
  output logic                                  target_region_o,
  output logic [rapd_pkg::OutCoordBits-1:0]     out_x_o,
  output logic [rapd_pkg::OutCoordBits-1:0]     out_y_o,
  output logic [rapd_pkg::ColorBits-1:0]        pixel_color_o,
  output logic                                  last_write_o,
  // configuration write channel
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [rapd_pkg::CfgIndexBits-1:0]     cfg_index_i,
  input  logic [rapd_pkg::CfgDataBits-1:0]      cfg_data_i
);

  localparam int unsigned MainAw  = $clog2(MAIN_SIDE * MAIN_SIDE);
  localparam int unsigned WinAw   = $clog2(WINDOW_SIDE * WINDOW_SIDE);
  localparam int unsigned LinBits = 21;  // 10-bit y times side up to 1024, plus x

  // ---------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------
  rapd_pkg::rapd_cfg_t cfg;

  assign cfg_ready_o = 1'b1;

  rapd_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_valid_i & cfg_ready_o),
    .index_i (cfg_index_i),
    .data_i  (cfg_data_i),
    .cfg_o   (cfg)
  );

  // ---------------------------------------------------------------------
  // Command decode and store addressing
  // ---------------------------------------------------------------------
  rapd_pkg::rapd_state_e state_q, state_d;
  logic clearing;
  logic accept;
  logic in_main, in_win;
  logic [LinBits-1:0] main_lin, win_lin;
  logic [MainAw-1:0]  main_addr;
  logic [WinAw-1:0]   win_addr;
  logic is_decay, is_load_main, is_load_win;

  assign busy   = clearing | (state_q != rapd_pkg::StIdle);
  assign accept = start & ~busy;

  assign in_main = ({1'b0, xpos_i} < 11'(MAIN_SIDE)) && ({1'b0, ypos_i} < 11'(MAIN_SIDE));
  assign in_win  = ({1'b0, xpos_i} < 11'(WINDOW_SIDE)) && ({1'b0, ypos_i} < 11'(WINDOW_SIDE));

  // Row-major address y*SIDE + x, constant multiplier
  assign main_lin  = LinBits'(ypos_i) * LinBits'(MAIN_SIDE) + LinBits'(xpos_i);
  assign win_lin   = LinBits'(ypos_i) * LinBits'(WINDOW_SIDE) + LinBits'(xpos_i);
  assign main_addr = in_main ? main_lin[MainAw-1:0] : '0;
  assign win_addr  = in_win ? win_lin[WinAw-1:0] : '0;

  assign is_decay     = (mode_i == rapd_pkg::ModeDecay);
  assign is_load_main = (mode_i == rapd_pkg::ModeLoadMain);
  assign is_load_win  = (mode_i == rapd_pkg::ModeLoadWindow);

  // ---------------------------------------------------------------------
  // Item registers held through the read-modify-write
  // ---------------------------------------------------------------------
  logic [rapd_pkg::CoordBits-1:0] x_q, y_q;
  logic                           in_main_q, in_win_q;
  logic [MainAw-1:0]              main_addr_q;
  logic [WinAw-1:0]               win_addr_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q         <= xpos_i;
      y_q         <= ypos_i;
      in_main_q   <= in_main;
      in_win_q    <= in_win;
      main_addr_q <= main_addr;
      win_addr_q  <= win_addr;
    end
  end

  // ---------------------------------------------------------------------
  // Pixel stores
  // ---------------------------------------------------------------------
  rapd_pkg::rapd_main_pix_t       main_rd, main_wd;
  rapd_pkg::rapd_win_pix_t        win_rd, win_wd;
  logic [rapd_pkg::ColorBits-1:0] ovl_rd;
  logic                           main_we, win_we, ovl_we;
  logic [MainAw-1:0]              main_wa;
  logic [WinAw-1:0]               win_wa;
  logic                           pix_rd_en;

  // Read only on an enabled decay accept so the overlay colour holds until output
  assign pix_rd_en = accept & is_decay & cfg.decay_enable;

  rapd_pixel_store #(
    .MAIN_SIDE   (MAIN_SIDE),
    .WINDOW_SIDE (WINDOW_SIDE)
  ) u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clearing_o   (clearing),
    .rd_en_i      (pix_rd_en),
    .main_raddr_i (main_addr),
    .win_raddr_i  (win_addr),
    .main_rdata_o (main_rd),
    .ovl_rdata_o  (ovl_rd),
    .win_rdata_o  (win_rd),
    .main_we_i    (main_we),
    .main_waddr_i (main_wa),
    .main_wdata_i (main_wd),
    .ovl_we_i     (ovl_we),
    .ovl_wdata_i  (overlay_color_i),
    .win_we_i     (win_we),
    .win_waddr_i  (win_wa),
    .win_wdata_i  (win_wd)
  );

  // ---------------------------------------------------------------------
  // Decay: hit test and saturating subtract on the read data
  // ---------------------------------------------------------------------
  logic                            main_hit, win_hit;
  logic [rapd_pkg::LevelBits-1:0]  main_nl, win_nl;
  logic                            emit_main_q, emit_main_d, emit_win_q, emit_win_d;
  logic                            ovl_flag_q, ovl_flag_d;

  assign main_hit = in_main_q && (x_q < cfg.main_width) && (y_q < cfg.main_height) &&
                    (main_rd.level != '0);
  assign win_hit  = cfg.window_enable && in_win_q &&
                    (x_q < {1'b0, cfg.window_width}) && (y_q < {1'b0, cfg.window_height}) &&
                    (win_rd.level != '0);

  assign main_nl = (main_rd.level > cfg.decay_weight) ? main_rd.level - cfg.decay_weight : '0;
  assign win_nl  = (win_rd.level > cfg.decay_weight) ? win_rd.level - cfg.decay_weight : '0;

  // Write port: loads at accept, write-back in the modify cycle
  always_comb begin
    main_we = 1'b0;
    win_we  = 1'b0;
    ovl_we  = 1'b0;
    main_wa = main_addr_q;
    win_wa  = win_addr_q;
    main_wd = main_rd;
    win_wd  = win_rd;
    main_wd.level = main_nl;
    win_wd.level  = win_nl;
    if (state_q == rapd_pkg::StModify) begin
      main_we = main_hit;
      win_we  = win_hit;
    end else if (accept) begin
      main_wa = main_addr;
      win_wa  = win_addr;
      main_wd.level        = level_i;
      main_wd.layer        = layer_num_i;
      main_wd.overlay_flag = overlay_on_i;
      win_wd.level         = level_i;
      win_wd.layer         = layer_num_i;
      main_we = is_load_main & in_main;
      ovl_we  = is_load_main & in_main;
      win_we  = is_load_win & in_win;
    end
  end

  // ---------------------------------------------------------------------
  // Palettes: written by loads, read at the faded level
  // ---------------------------------------------------------------------
  rapd_pkg::rapd_pal_wr_t         pal_wr;
  logic [rapd_pkg::ColorBits-1:0] main_col, win_col;

  assign pal_wr.main_we = accept & (mode_i == rapd_pkg::ModeMainPal);
  assign pal_wr.win_we  = accept & (mode_i == rapd_pkg::ModeWindowPal);
  assign pal_wr.idx     = palette_index_i;
  assign pal_wr.color   = palette_color_i;

  rapd_palette u_pal (
    .clk_i        (clk_i),
    .wr_i         (pal_wr),
    .rd_en_i      (state_q == rapd_pkg::StModify),
    .main_ridx_i  (main_nl),
    .win_ridx_i   (win_nl),
    .main_color_o (main_col),
    .win_color_o  (win_col)
  );

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  logic sel_win;

  always_comb begin
    state_d     = state_q;
    emit_main_d = emit_main_q;
    emit_win_d  = emit_win_q;
    ovl_flag_d  = ovl_flag_q;
    result_valid_o = 1'b0;
    sel_win        = 1'b0;
    last_write_o   = 1'b1;
    unique case (state_q)
      rapd_pkg::StIdle: begin
        if (pix_rd_en) state_d = rapd_pkg::StModify;
      end
      rapd_pkg::StModify: begin
        emit_main_d = main_hit && (main_rd.layer < rapd_pkg::VisibleLayers);
        emit_win_d  = win_hit && (win_rd.layer < rapd_pkg::VisibleLayers);
        ovl_flag_d  = main_rd.overlay_flag;
        state_d     = rapd_pkg::StOutMain;
      end
      rapd_pkg::StOutMain: begin
        result_valid_o = emit_main_q | emit_win_q;
        sel_win        = ~emit_main_q;
        last_write_o   = ~(emit_main_q & emit_win_q);
        state_d = (emit_main_q & emit_win_q) ? rapd_pkg::StOutWindow : rapd_pkg::StIdle;
      end
      rapd_pkg::StOutWindow: begin
        result_valid_o = 1'b1;
        sel_win        = 1'b1;
        state_d        = rapd_pkg::StIdle;
      end
      default: state_d = rapd_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rapd_pkg::StIdle;
      emit_main_q <= 1'b0;
      emit_win_q  <= 1'b0;
      ovl_flag_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      emit_main_q <= emit_main_d;
      emit_win_q  <= emit_win_d;
      ovl_flag_q  <= ovl_flag_d;
    end
  end

  // Result payload
  assign target_region_o = sel_win;
  assign out_x_o         = x_q[rapd_pkg::OutCoordBits-1:0];
  assign out_y_o         = y_q[rapd_pkg::OutCoordBits-1:0];
  assign pixel_color_o   = sel_win ? win_col : (ovl_flag_q ? (main_col ^ ovl_rd) : main_col);

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for the radar afterglow pixel decay block.
`timescale 1ns / 1ps

// Loads fill the pixel stores and both palettes. Decay commands fade pixels and
// produce framebuffer writes, which are checked one by one against a
// behavioural model held in a small scoreboard. Stimulus runs in phases. Each
// phase has its own register setting and its own sender idling. Registers are
// only rewritten once all writes due from the previous phase have arrived and
// the block has settled.
module tb_top;
  import rapd_pkg::*;

  localparam int unsigned MainSide    = MainSideDefault;
  localparam int unsigned WinSide     = WindowSideDefault;
  localparam int unsigned MainCells   = MainSide * MainSide;
  localparam int unsigned WinCells    = WinSide * WinSide;
  // modes the block must ignore
  localparam logic [2:0]  ModeSpareLo = 3'd5;
  localparam logic [2:0]  ModeSpareHi = 3'd7;
  localparam int unsigned HotDepth    = 20;    // live pixels revisited by fades
  localparam int unsigned MaxGap      = 40;    // longest sender pause
  localparam int unsigned SettleCyc   = 6;     // idle wait at the end of a drain
  localparam int unsigned DrainLimit  = 4000;
  localparam int unsigned NumPhases   = 7;
  localparam int unsigned PhaseItems  = 155;
  localparam int unsigned OffItems    = 80;    // phase with decay switched off

  typedef struct {
    logic [2:0]           mode;
    logic [CoordBits-1:0] x;
    logic [CoordBits-1:0] y;
    logic [LevelBits-1:0] level;
    logic [LayerBits-1:0] layer;
    logic                 ov_on;
    logic [ColorBits-1:0] ov_color;
    logic [7:0]           pal_idx;
    logic [ColorBits-1:0] pal_color;
  } pix_cmd_t;

  typedef struct {
    logic                    region;
    logic [OutCoordBits-1:0] x;
    logic [OutCoordBits-1:0] y;
    logic [ColorBits-1:0]    color;
    logic                    last;
  } fb_write_t;

  // Behavioural model of the fade engine plus the queue of writes it predicts.
  class afterglow_scoreboard;
    rapd_cfg_t          cfg;
    bit [LevelBits-1:0] main_lvl [MainCells];
    bit [LayerBits-1:0] main_lay [MainCells];
    bit                 main_ov  [MainCells];
    bit [ColorBits-1:0] main_ovc [MainCells];
    bit [LevelBits-1:0] win_lvl  [WinCells];
    bit [LayerBits-1:0] win_lay  [WinCells];
    bit [ColorBits-1:0] main_pal [PaletteDepth];
    bit [ColorBits-1:0] win_pal  [PaletteDepth];
    fb_write_t          pending_writes [$];
    int unsigned        errors, cmds, main_writes, window_writes, hidden_fades;

    function new();
      cfg.decay_weight  = DecayWeightReset;
      cfg.main_width    = MainWidthReset;
      cfg.main_height   = MainHeightReset;
      cfg.window_width  = WindowWidthReset;
      cfg.window_height = WindowHeightReset;
      cfg.window_enable = 1'b0;
      cfg.decay_enable  = 1'b1;
    endfunction

    function void set_reg(rapd_cfg_idx_e idx, logic [CfgDataBits-1:0] v);
      case (idx)
        CfgDecayWeight:  cfg.decay_weight  = v[7:0];
        CfgMainWidth:    cfg.main_width    = v[9:0];
        CfgMainHeight:   cfg.main_height   = v[9:0];
        CfgWindowWidth:  cfg.window_width  = v[8:0];
        CfgWindowHeight: cfg.window_height = v[8:0];
        CfgWindowEnable: cfg.window_enable = v[0];
        CfgDecayEnable:  cfg.decay_enable  = v[0];
        default: ;
      endcase
    endfunction

    function logic [LevelBits-1:0] fade(logic [LevelBits-1:0] lvl);
      return (lvl > cfg.decay_weight) ? lvl - cfg.decay_weight : '0;
    endfunction

    // Update the stores for one accepted command and queue the writes it causes.
    function void apply_cmd(pix_cmd_t c);
      bit                   in_main, in_win;
      int unsigned          mi, wi;
      logic [LevelBits-1:0] nl;
      logic [ColorBits-1:0] col;
      fb_write_t            w;
      fb_write_t            batch [$];
      cmds++;
      in_main = (c.x < MainSide) && (c.y < MainSide);
      in_win  = (c.x < WinSide) && (c.y < WinSide);
      mi = c.y * MainSide + c.x;
      wi = c.y * WinSide + c.x;
      case (c.mode)
        ModeLoadMain: if (in_main) begin
          main_lvl[mi] = c.level;
          main_lay[mi] = c.layer;
          main_ov[mi]  = c.ov_on;
          main_ovc[mi] = c.ov_color;
        end
        ModeLoadWindow: if (in_win) begin
          win_lvl[wi] = c.level;
          win_lay[wi] = c.layer;
        end
        ModeMainPal:   main_pal[c.pal_idx] = c.pal_color;
        ModeWindowPal: win_pal[c.pal_idx]  = c.pal_color;
        ModeDecay: if (cfg.decay_enable) begin
          if (in_main && c.x < cfg.main_width && c.y < cfg.main_height &&
              main_lvl[mi] != 0) begin
            nl = fade(main_lvl[mi]);
            main_lvl[mi] = nl;
            if (main_lay[mi] < VisibleLayers) begin
              col = main_pal[nl];
              if (main_ov[mi]) col ^= main_ovc[mi];
              w = '{region: 1'b0, x: c.x[8:0], y: c.y[8:0], color: col, last: 1'b0};
              batch.push_back(w);
            end else begin
              hidden_fades++;
            end
          end
          if (cfg.window_enable && in_win && c.x < cfg.window_width &&
              c.y < cfg.window_height && win_lvl[wi] != 0) begin
            nl = fade(win_lvl[wi]);
            win_lvl[wi] = nl;
            if (win_lay[wi] < VisibleLayers) begin
              w = '{region: 1'b1, x: c.x[8:0], y: c.y[8:0], color: win_pal[nl],
                    last: 1'b0};
              batch.push_back(w);
            end else begin
              hidden_fades++;
            end
          end
        end
        default: ;
      endcase
      if (batch.size() != 0) batch[batch.size()-1].last = 1'b1;
      foreach (batch[i]) pending_writes.push_back(batch[i]);
    endfunction

    function void check_write(fb_write_t got);
      fb_write_t exp;
      if (pending_writes.size() == 0) begin
        $error("unexpected write: region %0d x %0d y %0d colour %h",
               got.region, got.x, got.y, got.color);
        errors++;
        return;
      end
      exp = pending_writes.pop_front();
      if (got.region !== exp.region) begin
        $error("target_region: expected %0d, got %0d", exp.region, got.region);
        errors++;
      end
      if (got.x !== exp.x) begin
        $error("out_x: expected %0d, got %0d", exp.x, got.x);
        errors++;
      end
      if (got.y !== exp.y) begin
        $error("out_y: expected %0d, got %0d", exp.y, got.y);
        errors++;
      end
      if (got.color !== exp.color) begin
        $error("pixel_color: expected %h, got %h", exp.color, got.color);
        errors++;
      end
      if (got.last !== exp.last) begin
        $error("last_write: expected %0d, got %0d", exp.last, got.last);
        errors++;
      end
      if (exp.region) window_writes++;
      else main_writes++;
    endfunction
  endclass

  // Clock, reset and all block inputs start at known values
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                    start           = 1'b0;
  logic                    busy;
  logic [2:0]              mode_i          = '0;
  logic [CoordBits-1:0]    xpos_i          = '0;
  logic [CoordBits-1:0]    ypos_i          = '0;
  logic [LevelBits-1:0]    level_i         = '0;
  logic [LayerBits-1:0]    layer_num_i     = '0;
  logic                    overlay_on_i    = 1'b0;
  logic [ColorBits-1:0]    overlay_color_i = '0;
  logic [7:0]              palette_index_i = '0;
  logic [ColorBits-1:0]    palette_color_i = '0;
  logic                    result_valid_o;
  logic                    target_region_o;
  logic [OutCoordBits-1:0] out_x_o;
  logic [OutCoordBits-1:0] out_y_o;
  logic [ColorBits-1:0]    pixel_color_o;
  logic                    last_write_o;
  logic                    cfg_valid_i     = 1'b0;
  logic                    cfg_ready_o;
  logic [CfgIndexBits-1:0] cfg_index_i     = '0;
  logic [CfgDataBits-1:0]  cfg_data_i      = '0;

  afterglow_scoreboard sb;
  int unsigned         reg_writes;
  int unsigned         settings_used;

  // Pixels loaded recently; most fades go here so that stores are actually live
  logic [CoordBits-1:0] hot_x [$];
  logic [CoordBits-1:0] hot_y [$];

  always #5 clk_i = ~clk_i;

  radar_afterglow_pixel_decay_top dut (.*);

  // Monitor: everything is sampled at the rising edge, before any nonblocking
  // update of that edge lands, so the values seen are those that the block sees.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o === 1'b1)
        sb.check_write('{region: target_region_o, x: out_x_o, y: out_y_o,
                         color: pixel_color_o, last: last_write_o});
      if (start && busy === 1'b0)
        sb.apply_cmd('{mode: mode_i, x: xpos_i, y: ypos_i, level: level_i,
                       layer: layer_num_i, ov_on: overlay_on_i,
                       ov_color: overlay_color_i, pal_idx: palette_index_i,
                       pal_color: palette_color_i});
      if (cfg_valid_i && cfg_ready_o === 1'b1) begin
        sb.set_reg(rapd_cfg_idx_e'(cfg_index_i), cfg_data_i);
        reg_writes++;
      end
    end
  end

  // Present one command and hold it until the transfer happens. Start is left
  // high; the caller either presents the next command or lowers it in the
  // same step.
  task automatic send_cmd(input pix_cmd_t c);
    start           <= 1'b1;
    mode_i          <= c.mode;
    xpos_i          <= c.x;
    ypos_i          <= c.y;
    level_i         <= c.level;
    layer_num_i     <= c.layer;
    overlay_on_i    <= c.ov_on;
    overlay_color_i <= c.ov_color;
    palette_index_i <= c.pal_idx;
    palette_color_i <= c.pal_color;
    do @(posedge clk_i); while (busy !== 1'b0);
  endtask

  // Geometric pause: pct is the chance of each further idle cycle
  task automatic sender_gap(input int unsigned pct);
    int unsigned gap;
    gap = 0;
    while (gap < MaxGap && $urandom_range(99) < pct) gap++;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Hold off until every predicted write is in and the block has gone quiet
  task automatic drain();
    int unsigned guard;
    start <= 1'b0;
    @(posedge clk_i);
    for (guard = 0; guard < DrainLimit && (sb.pending_writes.size() != 0 ||
         busy !== 1'b0); guard++)
      @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic write_reg(input rapd_cfg_idx_e idx, input logic [CfgDataBits-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
  endtask

  task automatic load_setting(input logic [7:0] weight, input logic [9:0] mw,
                              input logic [9:0] mh, input logic [8:0] ww,
                              input logic [8:0] wh, input logic wen, input logic den);
    write_reg(CfgDecayWeight, CfgDataBits'(weight));
    write_reg(CfgMainWidth, mw);
    write_reg(CfgMainHeight, mh);
    write_reg(CfgWindowWidth, CfgDataBits'(ww));
    write_reg(CfgWindowHeight, CfgDataBits'(wh));
    write_reg(CfgWindowEnable, CfgDataBits'(wen));
    write_reg(CfgDecayEnable, CfgDataBits'(den));
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  // Fields not used by a mode still get random values
  function automatic pix_cmd_t random_cmd();
    pix_cmd_t c;
    c.mode      = ModeDecay;
    c.x         = CoordBits'($urandom_range(1023));
    c.y         = CoordBits'($urandom_range(1023));
    c.level     = LevelBits'($urandom_range(255));
    c.layer     = LayerBits'($urandom_range(3));
    c.ov_on     = 1'($urandom_range(1));
    c.ov_color  = ColorBits'($urandom_range(16'hFFFF));
    c.pal_idx   = 8'($urandom_range(255));
    c.pal_color = ColorBits'($urandom_range(16'hFFFF));
    return c;
  endfunction

  function automatic pix_cmd_t mk(input logic [2:0] mode, input int unsigned x,
                                  input int unsigned y, input int unsigned lvl,
                                  input int unsigned lay, input logic ov,
                                  input logic [15:0] ovc, input logic [7:0] pidx,
                                  input logic [15:0] pcol);
    pix_cmd_t c;
    c = '{mode: mode, x: CoordBits'(x), y: CoordBits'(y), level: LevelBits'(lvl),
          layer: LayerBits'(lay), ov_on: ov, ov_color: ovc, pal_idx: pidx,
          pal_color: pcol};
    return c;
  endfunction

  function automatic void remember(input logic [CoordBits-1:0] x,
                                   input logic [CoordBits-1:0] y);
    hot_x.push_back(x);
    hot_y.push_back(y);
    if (hot_x.size() > HotDepth) begin
      void'(hot_x.pop_front());
      void'(hot_y.pop_front());
    end
  endfunction

  // Mostly fades of live pixels (often back to back on the same one, and often
  // inside both regions), plus loads to keep pixels alive and some noise.
  function automatic pix_cmd_t next_cmd();
    pix_cmd_t    c;
    int unsigned roll, k;
    c    = random_cmd();
    roll = $urandom_range(99);
    if (hot_x.size() == 0 && roll < 42) roll = 50;
    if (roll < 42) begin
      k    = $urandom_range(hot_x.size() - 1);
      c.x  = hot_x[k];
      c.y  = hot_y[k];
    end else if (roll < 58) begin
      c.mode = ModeLoadMain;
      c.x    = CoordBits'($urandom_range(1) ? $urandom_range(WinSide - 1) :
                                              $urandom_range(MainSide - 1));
      c.y    = CoordBits'($urandom_range(1) ? $urandom_range(WinSide - 1) :
                                              $urandom_range(MainSide - 1));
      remember(c.x, c.y);
    end else if (roll < 70) begin
      c.mode = ModeLoadWindow;
      k      = hot_x.size() != 0 ? $urandom_range(hot_x.size() - 1) : 0;
      if (hot_x.size() != 0 && $urandom_range(1) && hot_x[k] < WinSide &&
          hot_y[k] < WinSide) begin
        c.x = hot_x[k];
        c.y = hot_y[k];
      end else begin
        c.x = CoordBits'($urandom_range(WinSide - 1));
        c.y = CoordBits'($urandom_range(WinSide - 1));
        remember(c.x, c.y);
      end
    end else if (roll < 78) begin
      // reload a live pixel of the main display
      c.mode = ModeLoadMain;
      if (hot_x.size() != 0) begin
        k   = $urandom_range(hot_x.size() - 1);
        c.x = hot_x[k];
        c.y = hot_y[k];
      end
    end else if (roll < 86) begin
      c.mode = $urandom_range(1) ? ModeMainPal : ModeWindowPal;
    end else if (roll < 93) begin
      // fade at a coordinate from the whole field range
    end else if (roll < 97) begin
      c.mode = $urandom_range(1) ? ModeLoadMain : ModeLoadWindow;
    end else begin
      c.mode = 3'($urandom_range(ModeSpareLo, ModeSpareHi));
    end
    return c;
  endfunction

  initial begin
    pix_cmd_t    c;
    int unsigned pct, burst, n_items;
    sb            = new();
    reg_writes    = 0;
    settings_used = 0;
    burst         = 0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    // the pixel stores are swept after reset; busy holds off commands meanwhile
    do @(posedge clk_i); while (busy !== 1'b0);

    load_setting(8'd60, 10'd512, 10'd512, 9'd256, 9'd256, 1'b1, 1'b1);

    // Fill both palettes so that no fade reads an entry never written
    for (int i = 0; i < PaletteDepth; i++) begin
      c = random_cmd();
      c.mode = ModeMainPal;
      c.pal_idx = 8'(i);
      send_cmd(c);
      c = random_cmd();
      c.mode = ModeWindowPal;
      c.pal_idx = 8'(i);
      send_cmd(c);
    end

    // Directed: palette extremes, coordinate extremes, both regions, hidden
    // layers, zero intensity, outside the stores and the spare modes
    send_cmd(mk(ModeMainPal, 0, 0, 0, 0, 1'b0, 16'h0000, 8'd0, 16'h0000));
    send_cmd(mk(ModeMainPal, 1023, 1023, 255, 3, 1'b1, 16'hFFFF, 8'd255, 16'hFFFF));
    send_cmd(mk(ModeWindowPal, 0, 0, 0, 0, 1'b0, 16'h0000, 8'd0, 16'hFFFF));
    send_cmd(mk(ModeWindowPal, 0, 0, 0, 0, 1'b0, 16'h0000, 8'd255, 16'h0000));
    send_cmd(mk(ModeLoadMain, 0, 0, 255, 0, 1'b1, 16'hA5A5, 8'd0, 16'h0000));
    send_cmd(mk(ModeLoadWindow, 0, 0, 255, 1, 1'b0, 16'h0000, 8'd0, 16'h0000));
    send_cmd(mk(ModeDecay, 0, 0, 0, 0, 1'b0, 16'h0000, 8'd0, 16'h0000));
    send_cmd(mk(ModeDecay, 0, 0, 255, 3, 1'b1, 16'hFFFF, 8'd255, 16'hFFFF));
    send_cmd(mk(ModeLoadMain, 511, 511, 1, 3, 1'b0, 16'h0000, 8'd0, 16'h0000));
    send_cmd(mk(ModeDecay, 511, 511, 0, 0, 1'b0, 16'h0000, 8'd0, 16'h0000));
    send_cmd(mk(ModeDecay, 511, 511, 0, 0, 1'b0, 16'h0000, 8'd0, 16'h0000));
    send_cmd(mk(ModeLoadMain, 512, 3, 200, 0, 1'b1, 16'h1234, 8'd0, 16'h0000));
    send_cmd(mk(ModeLoadWindow, 256, 0, 200, 0, 1'b0, 16'h0000, 8'd0, 16'h0000));
    send_cmd(mk(ModeDecay, 1023, 1023, 0, 0, 1'b0, 16'h0000, 8'd0, 16'h0000));
    send_cmd(mk(ModeDecay, 512, 3, 0, 0, 1'b0, 16'h0000, 8'd0, 16'h0000));
    send_cmd(mk(ModeLoadWindow, 255, 255, 60, 0, 1'b0, 16'h0000, 8'd0, 16'h0000));
    send_cmd(mk(ModeLoadMain, 255, 255, 0, 2, 1'b1, 16'hFFFF, 8'd0, 16'h0000));
    send_cmd(mk(ModeDecay, 255, 255, 0, 0, 1'b0, 16'h0000, 8'd0, 16'h0000));
    send_cmd(mk(ModeLoadMain, 10, 20, 255, 2, 1'b1, 16'h00FF, 8'd0, 16'h0000));
    send_cmd(mk(ModeDecay, 10, 20, 0, 0, 1'b0, 16'h0000, 8'd0, 16'h0000));
    send_cmd(mk(ModeLoadMain, 300, 200, 255, 1, 1'b0, 16'hFFFF, 8'd0, 16'h0000));
    send_cmd(mk(ModeDecay, 300, 200, 0, 0, 1'b0, 16'h0000, 8'd0, 16'h0000));
    send_cmd(mk(ModeSpareLo, 0, 0, 255, 0, 1'b0, 16'h0000, 8'd0, 16'h0000));
    send_cmd(mk(ModeSpareHi, 1, 1, 255, 0, 1'b1, 16'hFFFF, 8'd255, 16'hFFFF));

    // Random phases, each with its own setting; idling cycles none, heavy, light
    for (int p = 0; p < NumPhases; p++) begin
      drain();
      case (p)
        0: load_setting(8'd60, 10'd512, 10'd512, 9'd256, 9'd256, 1'b1, 1'b1);
        1: load_setting(8'd1, 10'd100, 10'd300, 9'd50, 9'd200, 1'b1, 1'b1);
        2: load_setting(8'd255, 10'd0, 10'd0, 9'd256, 9'd256, 1'b1, 1'b1);
        3: load_setting(8'd0, 10'd1023, 10'd1023, 9'd511, 9'd511, 1'b1, 1'b1);
        4: load_setting(8'($urandom_range(255)), 10'($urandom_range(1023)),
                        10'($urandom_range(1023)), 9'($urandom_range(511)),
                        9'($urandom_range(511)), 1'b0, 1'b0);
        5: load_setting(8'($urandom_range(1, 40)), 10'($urandom_range(512)),
                        10'($urandom_range(512)), 9'($urandom_range(256)),
                        9'($urandom_range(256)), 1'b1, 1'b1);
        default: load_setting(8'd60, 10'd512, 10'd256, 9'd128, 9'd256, 1'b0, 1'b1);
      endcase
      pct     = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 87 : 36;
      n_items = (p == 4) ? OffItems : PhaseItems;
      for (int n = 0; n < n_items; n++) begin
        // occasional bursts with no pauses even in the idling phases
        if (burst == 0 && $urandom_range(49) == 0) burst = $urandom_range(8, 24);
        if (burst != 0) burst--;
        else sender_gap(pct);
        send_cmd(next_cmd());
        // sender holds off until every write due so far has come back
        if ($urandom_range(199) == 0) drain();
      end
    end
    drain();

    if (sb.pending_writes.size() != 0) begin
      $error("%0d framebuffer writes never arrived", sb.pending_writes.size());
      sb.errors++;
    end
    $display("Run covered %0d commands over %0d register settings (%0d register writes).",
             sb.cmds, settings_used, reg_writes);
    $display("Checked %0d main and %0d window writes; %0d fades fell on hidden layers.",
             sb.main_writes, sb.window_writes, sb.hidden_fades);
    if (sb.errors == 0) begin
      $display("PASS radar_afterglow_pixel_decay_top");
    end else begin
      $display("FAIL radar_afterglow_pixel_decay_top");
    end
    $finish;
  end

  // Watchdog: the post-reset sweep plus the whole stimulus at its slowest,
  // several times over
  initial begin
    #(15_000_000);
    $display("FAIL radar_afterglow_pixel_decay_top");
    $finish;
  end

endmodule

// File: filelist.f
design/rapd_pkg.sv
design/rapd_cfg_regs.sv
design/rapd_pixel_store.sv
design/rapd_palette.sv
design/radar_afterglow_pixel_decay_top.sv
tb/sv/tb_top.sv
